@@ hw/rtl/wbcs_pkg.sv @@
// Shared types, constants and helper functions for the white blob centroid steering block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package wbcs_pkg;

	// Field and register widths fixed by the interface.
	localparam int CFG_W      = 13;
	localparam int PIX_W      = 8;
	localparam int STEER_W    = 3;
	localparam int MEAN_W     = 12;
	localparam int COUNT_W    = 24;
	// Column sum width and the width of a mean or threshold (widest possible image width).
	localparam int SUM_W      = 36;
	localparam int QUO_W      = 13;
	localparam int STEP_W     = $clog2(SUM_W + 1);

	// Parameter defaults.
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int COUNT_BITS_DEF = 24;

	// Register reset values.
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 13'd640;
	localparam logic [PIX_W-1:0] WHITE_LEVEL_RST = 8'd255;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_WHITE_LEVEL = 1'b1;

	// Steering codes.
	localparam logic [STEER_W-1:0] STEER_STOP     = 3'd0;
	localparam logic [STEER_W-1:0] STEER_LEFT     = 3'd1;
	localparam logic [STEER_W-1:0] STEER_CENTER   = 3'd2;
	localparam logic [STEER_W-1:0] STEER_RIGHT    = 3'd3;
	localparam logic [STEER_W-1:0] STEER_BOUNDARY = 3'd4;

	// Reciprocal of three scaled by 2^17; exact floor for any operand below 2^17.
	localparam int               RECIP3_SHIFT = 17;
	localparam logic [15:0]      RECIP3       = 16'd43691;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_HOLD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic pixel_take;
		logic frame_take;
		logic div_step;
		logic decide;
	} cmd_t;

	// Integer division by three of a value below 2^17, truncated to QUO_W bits.
	function automatic logic [QUO_W-1:0] div3(input logic [RECIP3_SHIFT-1:0] x);
		logic [RECIP3_SHIFT+15:0] prod;
		prod = (RECIP3_SHIFT+16)'(x) * (RECIP3_SHIFT+16)'(RECIP3);
		return QUO_W'(prod >> RECIP3_SHIFT);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wbcs_ctrl.sv @@
// Controller state machine: input and output handshakes and sequencing of the frame-end divide.
// Depends on wbcs_pkg.
`default_nettype none

module wbcs_ctrl
	import wbcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic frame_end,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t             state_q;
	state_t             state_d;
	logic [STEP_W-1:0]  step_q;
	logic               accept;

	// A frame-end beat needs the back end free; ordinary pixels always pass.
	assign in_ready = !frame_end || (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// State register and divide step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		out_valid      = 1'b0;
		cmd.pixel_take = accept;
		cmd.frame_take = accept && frame_end;
		cmd.div_step   = 1'b0;
		cmd.decide     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && frame_end) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_HOLD;
			end
			ST_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/wbcs_accum.sv @@
// Front datapath: configuration registers, column tracking and white pixel accumulation.
// Depends on wbcs_pkg.
`default_nettype none

module wbcs_accum
	import wbcs_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire cmd_t                  cmd,
	input  wire logic [PIX_W-1:0]      red,
	input  wire logic [PIX_W-1:0]      green,
	input  wire logic [PIX_W-1:0]      blue,
	output logic [CFG_W-1:0]           eff_width,
	output logic [SUM_W-1:0]           sum_next,
	output logic [COUNT_BITS-1:0]      hits_next
);

	// Column counter width: enough for MAX_WIDTH, never more than the register allows.
	localparam int COL_W = ($clog2(MAX_WIDTH) < CFG_W) ? $clog2(MAX_WIDTH) : CFG_W;

	logic [CFG_W-1:0]      image_width_q;
	logic [PIX_W-1:0]      white_level_q;
	logic [COL_W-1:0]      col_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] hits_q;
	logic                  hit;
	logic [SUM_W:0]        sum_add;
	logic [CFG_W:0]        col_inc;
	logic [COL_W-1:0]      col_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			white_level_q <= WHITE_LEVEL_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				REG_WHITE_LEVEL: white_level_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective width: zero acts as one, values above MAX_WIDTH are clamped.
	always_comb begin
		if (image_width_q == '0) begin
			eff_width = CFG_W'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			eff_width = CFG_W'(MAX_WIDTH);
		end else begin
			eff_width = image_width_q;
		end
	end

	// A white pixel counts until the hit counter is full; the sum saturates on its own.
	always_comb begin
		hit = (red == white_level_q) && (green == white_level_q) &&
			(blue == white_level_q) && (hits_q != '1);
		sum_add = {1'b0, sum_q} + (SUM_W+1)'(col_q);
		if (hit) begin
			hits_next = hits_q + 1'b1;
			sum_next  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		end else begin
			hits_next = hits_q;
			sum_next  = sum_q;
		end
	end

	// Column wraps once the next column reaches the width.
	always_comb begin
		col_inc  = (CFG_W+1)'(col_q) + 1'b1;
		col_next = (col_inc >= {1'b0, eff_width}) ? '0 : COL_W'(col_inc);
	end

	// Frame state; a frame-end beat hands the totals to the back end and clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			sum_q  <= '0;
			hits_q <= '0;
		end else if (cmd.frame_take) begin
			col_q  <= '0;
			sum_q  <= '0;
			hits_q <= '0;
		end else if (cmd.pixel_take) begin
			col_q  <= col_next;
			sum_q  <= sum_next;
			hits_q <= hits_next;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/wbcs_div.sv @@
// Back datapath: bit-serial restoring divider for the mean, thresholds and steering decision.
// Depends on wbcs_pkg.
`default_nettype none

module wbcs_div
	import wbcs_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire cmd_t                  cmd,
	input  wire logic [CFG_W-1:0]      eff_width,
	input  wire logic [SUM_W-1:0]      sum_next,
	input  wire logic [COUNT_BITS-1:0] hits_next,
	output logic [STEER_W-1:0]         steer_code,
	output logic [MEAN_W-1:0]          mean_column,
	output logic [COUNT_W-1:0]         white_count
);

	logic [SUM_W-1:0]      dvd_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [QUO_W-1:0]      t1_q;
	logic [QUO_W-1:0]      t2_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;
	logic [STEER_W-1:0]    code;

	// Region thresholds, refreshed every cycle from the effective width.
	always_ff @(posedge clk) begin
		t1_q <= div3(RECIP3_SHIFT'(eff_width));
		t2_q <= div3(RECIP3_SHIFT'({eff_width, 1'b0}));
	end

	// One quotient bit per step: shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.frame_take) begin
			dvd_q <= sum_next;
			dvs_q <= hits_next;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	// Steering decision from the mean and the thresholds.
	always_comb begin
		if (dvs_q == '0) begin
			code = STEER_STOP;
		end else if (quo_q < t1_q) begin
			code = STEER_LEFT;
		end else if (quo_q > t1_q && quo_q < t2_q) begin
			code = STEER_CENTER;
		end else if (quo_q > t2_q) begin
			code = STEER_RIGHT;
		end else begin
			code = STEER_BOUNDARY;
		end
	end

	// Output register, held until the beat is taken.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			steer_code  <= code;
			mean_column <= (dvs_q == '0) ? '0 : quo_q[MEAN_W-1:0];
			white_count <= COUNT_W'(dvs_q);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/white_blob_centroid_steer.sv @@
// White blob column centroid and steering: top level joining controller and datapath.
// Depends on wbcs_pkg, wbcs_ctrl, wbcs_accum and wbcs_div.
//
// Usage:
//   Pixels enter on the in_valid/in_ready channel in raster order, one beat per pixel,
//   with frame_end set on the last pixel of a frame. Ordinary pixels are taken every
//   cycle. The frame-end beat hands the column sum and white count to a bit-serial
//   divider and clears the frame state, so the next frame's pixels keep flowing.
//   The divider works through the column sum bits one by one, then the decision is made;
//   the result beat (steer_code, mean_column, white_count) then shows on out_valid and
//   stays until out_ready takes it.
//   A further frame-end beat is held off (in_ready low) until the previous result has
//   been taken, so a stalled receiver stalls the stream only at the next frame end.
//   Configuration is written through cfg_write_en/cfg_index/cfg_data while the block is
//   idle; index 0 is the image width, index 1 the white level.
//   Reset restores width 640 and white level 255, clears the column, sum and count,
//   and leaves no result pending.
`default_nettype none

module white_blob_centroid_steer
	import wbcs_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write_en,
	input  wire logic                cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [PIX_W-1:0]    red,
	input  wire logic [PIX_W-1:0]    green,
	input  wire logic [PIX_W-1:0]    blue,
	input  wire logic                frame_end,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STEER_W-1:0]       steer_code,
	output logic [MEAN_W-1:0]        mean_column,
	output logic [COUNT_W-1:0]       white_count
);

	cmd_t                  cmd;
	logic [CFG_W-1:0]      eff_width;
	logic [SUM_W-1:0]      sum_next;
	logic [COUNT_BITS-1:0] hits_next;

	// Handshakes and sequencing.
	wbcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.frame_end (frame_end),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Per-pixel accumulation.
	wbcs_accum #(
		.MAX_WIDTH  (MAX_WIDTH),
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.eff_width    (eff_width),
		.sum_next     (sum_next),
		.hits_next    (hits_next)
	);

	// Frame-end divide and decision.
	wbcs_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk         (clk),
		.cmd         (cmd),
		.eff_width   (eff_width),
		.sum_next    (sum_next),
		.hits_next   (hits_next),
		.steer_code  (steer_code),
		.mean_column (mean_column),
		.white_count (white_count)
	);

endmodule

`default_nettype wire
